// ----- rtl/deadlock_detection_engine_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the deadlock detection engine
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DEADLOCK_DETECTION_ENGINE_ASSERT_SVH
`define DEADLOCK_DETECTION_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define DDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define DDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dde_pkg.sv -----
// ---------------------------------------------------------------------------
// dde_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package dde_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_MAX_RESOURCES = 8;

    localparam int MODE_W   = 2;
    localparam int PIDX_W   = 4;
    localparam int RIDX_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int AVAIL_W  = 21;
    localparam int PCOUNT_W = 5;
    localparam int RCOUNT_W = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;
    localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 4'd8;

    // Register select is byte address bit 2
    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_AVAIL   = 2'd2,
        MODE_RUN     = 2'd3
    } mode_t;

    typedef struct packed {
        logic load_wr;       // store a load transaction
        logic run_init;      // clear marks, counters, progress
        logic pass_restart;  // back to process 0, clear progress
        logic p_inc;
        logic r_clr;
        logic r_inc;
        logic add_wr;        // add allocation entry into available
        logic finish;        // mark process, append to sequence
        logic emit_init;
        logic emit_seq;
        logic emit_dead;
    } dde_cmd_t;

    typedef struct packed {
        logic p_end;
        logic fin_cur;
        logic all_done;
        logic progress;
        logic fits;
        logic r_last;
        logic emit_last;
    } dde_status_t;

endpackage

// ----- rtl/dde_ctrl.sv -----
// ---------------------------------------------------------------------------
// dde_ctrl
// Sequencer for loads, detection passes and result emission.
// ---------------------------------------------------------------------------
module dde_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [dde_pkg::MODE_W-1:0]       mode,
    input  dde_pkg::dde_status_t             status,
    output dde_pkg::dde_cmd_t                cmd,
    output logic                             busy
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SEL     = 7'b0000010,
        S_CHK_RD  = 7'b0000100,
        S_CHK_CMP = 7'b0001000,
        S_ADD_RD  = 7'b0010000,
        S_ADD_WR  = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == dde_pkg::MODE_RUN)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = S_SEL;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_SEL:
            begin
                if (status.p_end)
                begin
                    if (status.all_done)
                    begin
                        cmd.emit_init = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else if (!status.progress)
                    begin
                        cmd.emit_dead = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.pass_restart = 1'b1;
                    end
                end
                else if (status.fin_cur)
                begin
                    cmd.p_inc = 1'b1;
                end
                else
                begin
                    cmd.r_clr  = 1'b1;
                    state_next = S_CHK_RD;
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (!status.fits)
                begin
                    // request exceeds what is available: skip this process
                    cmd.p_inc  = 1'b1;
                    state_next = S_SEL;
                end
                else if (status.r_last)
                begin
                    cmd.r_clr  = 1'b1;
                    state_next = S_ADD_RD;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_CHK_RD;
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                if (status.r_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.p_inc  = 1'b1;
                    state_next = S_SEL;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_EMIT:
            begin
                cmd.emit_seq = 1'b1;
                if (status.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/dde_datapath.sv -----
// ---------------------------------------------------------------------------
// dde_datapath
// Matrices, available vector, finish marks, safe sequence and result register.
// ---------------------------------------------------------------------------
module dde_datapath
#(
    parameter int MAX_PROCESSES = dde_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = dde_pkg::DEF_MAX_RESOURCES,
    parameter int CW            = $clog2(MAX_PROCESSES + 1),
    parameter int CRW           = $clog2(MAX_RESOURCES + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dde_pkg::dde_cmd_t                  cmd,
    input  logic [dde_pkg::MODE_W-1:0]         mode,
    input  logic [dde_pkg::PIDX_W-1:0]         process_index,
    input  logic [dde_pkg::RIDX_W-1:0]         resource_index,
    input  logic [dde_pkg::VALUE_W-1:0]        value,
    input  logic [CW-1:0]                      proc_num,
    input  logic [CRW-1:0]                     res_num,
    output dde_pkg::dde_status_t               status,
    output logic                               result_valid,
    output logic                               deadlock,
    output logic [dde_pkg::PIDX_W-1:0]         process_id,
    output logic                               last
);

    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = dde_pkg::VALUE_W;
    localparam int AVW   = dde_pkg::AVAIL_W;
    localparam logic [AVW-1:0] AVAIL_SAT = {AVW{1'b1}};

    logic [VW-1:0]   alloc_mem [DEPTH];
    logic [VW-1:0]   req_mem   [DEPTH];
    logic [AVW-1:0]  avail_mem [MAX_RESOURCES];
    logic [PW-1:0]   seq_mem   [MAX_PROCESSES];

    logic [VW-1:0]            alloc_rd_reg;
    logic [VW-1:0]            req_rd_reg;
    logic [AVW-1:0]           avail_rd_reg;
    logic [CW-1:0]            p_reg;
    logic [RW-1:0]            r_reg;
    logic [CW-1:0]            fcount_reg;
    logic                     progress_reg;
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic                     result_valid_reg;
    logic                     deadlock_reg;
    logic [dde_pkg::PIDX_W-1:0] process_id_reg;
    logic                     last_reg;

    logic [PW-1:0]   p_idx;
    logic [AW-1:0]   run_addr;
    logic [AW-1:0]   ld_addr;
    logic [RW-1:0]   ld_ridx;
    logic            ld_pi_ok;
    logic            ld_ri_ok;
    logic            alloc_we;
    logic            req_we;
    logic [AVW:0]    avail_sum;
    logic [AVW-1:0]  avail_sat_sum;

    assign p_idx    = p_reg[PW-1:0];
    assign run_addr = AW'(int'(p_idx) * MAX_RESOURCES + int'(r_reg));
    assign ld_addr  = AW'(int'(process_index) * MAX_RESOURCES + int'(resource_index));
    assign ld_ridx  = RW'(resource_index);
    assign ld_pi_ok = (int'(process_index) < MAX_PROCESSES);
    assign ld_ri_ok = (int'(resource_index) < MAX_RESOURCES);
    assign alloc_we = cmd.load_wr && ld_pi_ok && ld_ri_ok && (mode == dde_pkg::MODE_ALLOC);
    assign req_we   = cmd.load_wr && ld_pi_ok && ld_ri_ok && (mode == dde_pkg::MODE_REQUEST);

    // Saturating add keeps a full entry above any request
    assign avail_sum     = {1'b0, avail_rd_reg} + (AVW + 1)'(alloc_rd_reg);
    assign avail_sat_sum = avail_sum[AVW] ? AVAIL_SAT : avail_sum[AVW-1:0];

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[ld_addr] <= value;
        end
        alloc_rd_reg <= alloc_mem[run_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req_we)
        begin
            req_mem[ld_addr] <= value;
        end
        req_rd_reg <= req_mem[run_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ld_ri_ok && (mode == dde_pkg::MODE_AVAIL))
        begin
            avail_mem[ld_ridx] <= AVW'(value);
        end
        else if (cmd.add_wr)
        begin
            avail_mem[r_reg] <= avail_sat_sum;
        end
        avail_rd_reg <= avail_mem[r_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            seq_mem[fcount_reg[PW-1:0]] <= p_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            r_reg        <= '0;
            fcount_reg   <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            if (cmd.run_init || cmd.pass_restart || cmd.emit_init)
            begin
                p_reg <= '0;
            end
            else if (cmd.p_inc || cmd.emit_seq)
            begin
                p_reg <= p_reg + CW'(1);
            end

            if (cmd.r_clr)
            begin
                r_reg <= '0;
            end
            else if (cmd.r_inc)
            begin
                r_reg <= r_reg + RW'(1);
            end

            if (cmd.run_init)
            begin
                fcount_reg   <= '0;
                finished_reg <= '0;
            end
            else if (cmd.finish)
            begin
                fcount_reg          <= fcount_reg + CW'(1);
                finished_reg[p_idx] <= 1'b1;
            end

            if (cmd.run_init || cmd.pass_restart)
            begin
                progress_reg <= 1'b0;
            end
            else if (cmd.finish)
            begin
                progress_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_seq || cmd.emit_dead;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_dead)
        begin
            deadlock_reg   <= 1'b1;
            process_id_reg <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_seq)
        begin
            deadlock_reg   <= 1'b0;
            process_id_reg <= dde_pkg::PIDX_W'(seq_mem[p_idx]);
            last_reg       <= status.emit_last;
        end
    end

    assign status.p_end     = (p_reg >= proc_num);
    assign status.fin_cur   = finished_reg[p_idx];
    assign status.all_done  = (fcount_reg == proc_num);
    assign status.progress  = progress_reg;
    assign status.fits      = (AVW'(req_rd_reg) <= avail_rd_reg);
    assign status.r_last    = (CRW'(r_reg) == res_num - CRW'(1));
    assign status.emit_last = (p_reg == proc_num - CW'(1));

    assign result_valid = result_valid_reg;
    assign deadlock     = deadlock_reg;
    assign process_id   = process_id_reg;
    assign last         = last_reg;

endmodule

// ----- rtl/deadlock_detection_engine.sv -----
// ---------------------------------------------------------------------------
// deadlock_detection_engine
// Resource-allocation deadlock detection with a load/run command interface.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. Modes 0, 1
//   and 2 write one allocation, request or available entry; busy stays low,
//   and back-to-back loads go in every cycle.
//   Mode 3 runs detection; busy falls in the cycle that carries the last result.
// Course of a run:
//   Each examined process costs a select state, then a read and a compare
//   state per resource compared, and a read and a write state per resource
//   when it finishes; the single read port of each matrix sets this. At
//   most process_count passes are made. A safe run then issues
//   process_count results on consecutive cycles, the first registered out
//   of the emit state that follows the select cycle closing the last pass;
//   a deadlocked run issues one result in the cycle after that select cycle.
// Results:
//   result_valid marks each result for exactly one cycle; the receiver
//   must take it then, there is no back-pressure.
// Reset:
//   Registers return to process_count 16, resource_count 8; the finish marks
//   clear. Matrices and the available vector are undefined until written.
// ---------------------------------------------------------------------------
`include "deadlock_detection_engine_assert.svh"

module deadlock_detection_engine
#(
    parameter int MAX_PROCESSES = dde_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = dde_pkg::DEF_MAX_RESOURCES
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dde_pkg::MODE_W-1:0]         mode,
    input  logic [dde_pkg::PIDX_W-1:0]         process_index,
    input  logic [dde_pkg::RIDX_W-1:0]         resource_index,
    input  logic [dde_pkg::VALUE_W-1:0]        value,
    output logic                               result_valid,
    output logic                               deadlock,
    output logic [dde_pkg::PIDX_W-1:0]         process_id,
    output logic                               last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dde_pkg::APB_AW-1:0]         paddr,
    input  logic [dde_pkg::APB_DW-1:0]         pwdata,
    output logic [dde_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int CRW = $clog2(MAX_RESOURCES + 1);

    logic [dde_pkg::PCOUNT_W-1:0] pcount_reg;
    logic [dde_pkg::RCOUNT_W-1:0] rcount_reg;
    logic                         cfg_wr;
    logic [CW-1:0]                proc_num;
    logic [CRW-1:0]               res_num;
    dde_pkg::dde_cmd_t            cmd;
    dde_pkg::dde_status_t         status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= dde_pkg::PCOUNT_RESET;
            rcount_reg <= dde_pkg::RCOUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == dde_pkg::REG_PROCESS_COUNT)
            begin
                pcount_reg <= pwdata[dde_pkg::PCOUNT_W-1:0];
            end
            else
            begin
                rcount_reg <= pwdata[dde_pkg::RCOUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == dde_pkg::REG_RESOURCE_COUNT)
        begin
            prdata = dde_pkg::APB_DW'(rcount_reg);
        end
        else
        begin
            prdata = dde_pkg::APB_DW'(pcount_reg);
        end
    end

    // Clamp the counts in use into 1..max
    always_comb
    begin
        if (pcount_reg == '0)
        begin
            proc_num = CW'(1);
        end
        else if (int'(pcount_reg) > MAX_PROCESSES)
        begin
            proc_num = CW'(MAX_PROCESSES);
        end
        else
        begin
            proc_num = CW'(pcount_reg);
        end

        if (rcount_reg == '0)
        begin
            res_num = CRW'(1);
        end
        else if (int'(rcount_reg) > MAX_RESOURCES)
        begin
            res_num = CRW'(MAX_RESOURCES);
        end
        else
        begin
            res_num = CRW'(rcount_reg);
        end
    end

    dde_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dde_datapath
    #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .CW            (CW),
        .CRW           (CRW)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .process_index  (process_index),
        .resource_index (resource_index),
        .value          (value),
        .proc_num       (proc_num),
        .res_num        (res_num),
        .status         (status),
        .result_valid   (result_valid),
        .deadlock       (deadlock),
        .process_id     (process_id),
        .last           (last)
    );

    `DDE_ASSERT_NEXT(a_run_goes_busy,
        start && !busy && (mode == dde_pkg::MODE_RUN), busy,
        "run transaction did not start the search")
    `DDE_ASSERT_SAME(a_deadlock_is_final,
        result_valid && deadlock, last && (process_id == '0),
        "deadlock result not final or id not zero")
    `DDE_ASSERT_NEXT(a_gap_after_last,
        result_valid && last, !result_valid,
        "result issued right after the final one")
    `DDE_ASSERT_SAME(a_result_while_busy,
        result_valid, $past(busy),
        "result issued without a run in progress")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadlock detection engine. Every matrix and
// available entry is loaded first, then a directed table and random
// scenarios (ordered chains, broken chains, noise loads) are issued under
// random start gaps and register settings. Each safe-sequence or deadlock
// result is checked against an untimed model of the detection passes or a typed outcome.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int NPROC        = dde_pkg::DEF_MAX_PROCESSES;
    localparam int NRES         = dde_pkg::DEF_MAX_RESOURCES;
    localparam int RANDOM_ITEMS = 100;
    localparam int STALL_LIMIT  = 50000;
    localparam int TAIL_CYCLES  = 32;
    localparam logic [dde_pkg::AVAIL_W-1:0] AVAIL_CEIL = {dde_pkg::AVAIL_W{1'b1}};

    typedef struct packed {
        logic                        deadlock;
        logic [dde_pkg::PIDX_W-1:0]  process_id;
        logic                        last;
    } outcome_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_PCOUNT,
        ROW_RCOUNT
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        dde_pkg::mode_t              op;
        logic [dde_pkg::PIDX_W-1:0]  pidx;
        logic [dde_pkg::RIDX_W-1:0]  ridx;
        logic [dde_pkg::VALUE_W-1:0] units;
        logic                        typed;
        outcome_t                    outcome;
    } stim_row_t;

    localparam outcome_t NO_OUTCOME   = '{1'b0, 4'd0, 1'b0};
    localparam outcome_t DEAD_OUTCOME = '{1'b1, 4'd0, 1'b1};
    localparam outcome_t SOLE_OUTCOME = '{1'b0, 4'd0, 1'b1};

    // Stores are all zero when this table starts
    localparam stim_row_t DIRECTED [23] = '{
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME},
        '{ROW_PCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd1,    1'b0, NO_OUTCOME},
        '{ROW_RCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd1,    1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_REQUEST, 4'd0,  3'd0, 16'hFFFF, 1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_AVAIL,   4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b1, DEAD_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_ALLOC,   4'd0,  3'd0, 16'hFFFF, 1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_AVAIL,   4'd0,  3'd0, 16'hFFFF, 1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b1, SOLE_OUTCOME},
        '{ROW_PCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME},
        '{ROW_RCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b1, SOLE_OUTCOME},
        '{ROW_PCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd31,   1'b0, NO_OUTCOME},
        '{ROW_RCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd15,   1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_REQUEST, 4'd0,  3'd7, 16'd100,  1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_ALLOC,   4'd15, 3'd7, 16'd100,  1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_REQUEST, 4'd15, 3'd7, 16'hFFFF, 1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b1, DEAD_OUTCOME},
        '{ROW_PCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd16,   1'b0, NO_OUTCOME},
        '{ROW_RCOUNT, dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd8,    1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_AVAIL,   4'd0,  3'd7, 16'hFFFF, 1'b0, NO_OUTCOME},
        '{ROW_ITEM,   dde_pkg::MODE_RUN,     4'd0,  3'd0, 16'd0,    1'b0, NO_OUTCOME}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [dde_pkg::MODE_W-1:0]    mode;
    logic [dde_pkg::PIDX_W-1:0]    process_index;
    logic [dde_pkg::RIDX_W-1:0]    resource_index;
    logic [dde_pkg::VALUE_W-1:0]   value;
    logic                          result_valid;
    logic                          deadlock;
    logic [dde_pkg::PIDX_W-1:0]    process_id;
    logic                          last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dde_pkg::APB_AW-1:0]    paddr;
    logic [dde_pkg::APB_DW-1:0]    pwdata;
    logic [dde_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    // Model state
    logic [dde_pkg::VALUE_W-1:0]   alloc_mat [NPROC][NRES];
    logic [dde_pkg::VALUE_W-1:0]   req_mat [NPROC][NRES];
    logic [dde_pkg::AVAIL_W-1:0]   avail_vec [NRES];
    logic [dde_pkg::PCOUNT_W-1:0]  pcount_reg;
    logic [dde_pkg::RCOUNT_W-1:0]  rcount_reg;
    outcome_t                      run_outcome [NPROC];
    int                            run_outcome_len;

    outcome_t                      expected_results [$];
    int                            result_errors = 0;
    int                            register_errors;
    int                            stall_cycles = 0;
    logic                          no_idle;

    deadlock_detection_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .process_index  (process_index),
        .resource_index (resource_index),
        .value          (value),
        .result_valid   (result_valid),
        .deadlock       (deadlock),
        .process_id     (process_id),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 clk = ~clk;

    function automatic int active_count(input int raw, input int top);
        if (raw < 1)
            return 1;
        if (raw > top)
            return top;
        return raw;
    endfunction

    function automatic logic [dde_pkg::VALUE_W-1:0] rand_units();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return dde_pkg::VALUE_W'($urandom_range(0, 7));
            default: return dde_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Apply one transaction to the model; a run leaves its results in run_outcome
    task automatic predict_detection(input dde_pkg::mode_t op,
                                     input logic [dde_pkg::PIDX_W-1:0] pi,
                                     input logic [dde_pkg::RIDX_W-1:0] ri,
                                     input logic [dde_pkg::VALUE_W-1:0] units);
        int                         np;
        int                         nr;
        int                         done_count;
        logic [NPROC-1:0]           done;
        logic                       progress;
        logic                       fits;
        logic [dde_pkg::AVAIL_W:0]  sum;
        logic [dde_pkg::PIDX_W-1:0] order [NPROC];
        run_outcome_len = 0;
        case (op)
            dde_pkg::MODE_ALLOC:   alloc_mat[pi][ri] = units;
            dde_pkg::MODE_REQUEST: req_mat[pi][ri] = units;
            dde_pkg::MODE_AVAIL:   avail_vec[ri] = dde_pkg::AVAIL_W'(units);
            dde_pkg::MODE_RUN:
            begin
                np = active_count(int'(pcount_reg), NPROC);
                nr = active_count(int'(rcount_reg), NRES);
                done = '0;
                done_count = 0;
                progress = 1'b1;
                while (done_count < np && progress)
                begin
                    progress = 1'b0;
                    for (int p = 0; p < np; p++)
                    begin
                        if (!done[p])
                        begin
                            fits = 1'b1;
                            for (int r = 0; r < nr; r++)
                                if (dde_pkg::AVAIL_W'(req_mat[p][r]) > avail_vec[r])
                                    fits = 1'b0;
                            if (fits)
                            begin
                                // the grown vector is seen by later processes of this pass
                                for (int r = 0; r < nr; r++)
                                begin
                                    sum = {1'b0, avail_vec[r]} +
                                          (dde_pkg::AVAIL_W+1)'(alloc_mat[p][r]);
                                    avail_vec[r] = (sum > {1'b0, AVAIL_CEIL}) ?
                                                   AVAIL_CEIL : sum[dde_pkg::AVAIL_W-1:0];
                                end
                                order[done_count] = dde_pkg::PIDX_W'(p);
                                done[p] = 1'b1;
                                done_count++;
                                progress = 1'b1;
                            end
                        end
                    end
                end
                if (done_count == np)
                begin
                    for (int k = 0; k < np; k++)
                    begin
                        run_outcome[k].deadlock = 1'b0;
                        run_outcome[k].process_id = order[k];
                        run_outcome[k].last = (k == np - 1);
                    end
                    run_outcome_len = np;
                end
                else
                begin
                    run_outcome[0] = DEAD_OUTCOME;
                    run_outcome_len = 1;
                end
            end
        endcase
    endtask

    // Drive one transaction and record what it must produce once accepted
    task automatic issue_command(input dde_pkg::mode_t op,
                                 input logic [dde_pkg::PIDX_W-1:0] pi,
                                 input logic [dde_pkg::RIDX_W-1:0] ri,
                                 input logic [dde_pkg::VALUE_W-1:0] units,
                                 input logic typed, input outcome_t typed_outcome);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= op;
        process_index <= pi;
        resource_index <= ri;
        value <= units;
        do
            @(posedge clk);
        while (busy);
        predict_detection(op, pi, ri, units);
        if (typed)
            expected_results.push_back(typed_outcome);
        else
            for (int k = 0; k < run_outcome_len; k++)
                expected_results.push_back(run_outcome[k]);
    endtask

    // Hold off until the engine is idle and all results are in
    task automatic settle_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_sel,
                                  input logic [dde_pkg::APB_DW-1:0] data);
        logic [dde_pkg::APB_DW-1:0] readback;
        if (reg_sel == dde_pkg::REG_PROCESS_COUNT)
        begin
            readback = dde_pkg::APB_DW'(data[dde_pkg::PCOUNT_W-1:0]);
            pcount_reg = data[dde_pkg::PCOUNT_W-1:0];
        end
        else
        begin
            readback = dde_pkg::APB_DW'(data[dde_pkg::RCOUNT_W-1:0]);
            rcount_reg = data[dde_pkg::RCOUNT_W-1:0];
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write commits at this edge; turn straight into a read-back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback)
        begin
            $error("prdata: expected %0d, actual %0d", readback, prdata);
            register_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t head;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: deadlock %0d process_id %0d last %0d",
                       deadlock, process_id, last);
                result_errors++;
            end
            else
            begin
                head = expected_results.pop_front();
                if (deadlock !== head.deadlock)
                begin
                    $error("deadlock: expected %0d, actual %0d", head.deadlock, deadlock);
                    result_errors++;
                end
                if (process_id !== head.process_id)
                begin
                    $error("process_id: expected %0d, actual %0d", head.process_id, process_id);
                    result_errors++;
                end
                if (last !== head.last)
                begin
                    $error("last: expected %0d, actual %0d", head.last, last);
                    result_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int                          random_items;
        int                          np;
        int                          nr;
        int                          rr;
        int                          j;
        int                          tmp;
        int                          victim;
        int                          loads;
        int                          rank [NPROC];
        logic [dde_pkg::VALUE_W-1:0] units;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = dde_pkg::MODE_ALLOC;
        process_index = '0;
        resource_index = '0;
        value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        register_errors = 0;
        no_idle = 1'b1;
        pcount_reg = dde_pkg::PCOUNT_RESET;
        rcount_reg = dde_pkg::RCOUNT_RESET;
        run_outcome_len = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every entry so that no run ever reads an unwritten one
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
            begin
                issue_command(dde_pkg::MODE_ALLOC, dde_pkg::PIDX_W'(p),
                              dde_pkg::RIDX_W'(r), '0, 1'b0, NO_OUTCOME);
                issue_command(dde_pkg::MODE_REQUEST, dde_pkg::PIDX_W'(p),
                              dde_pkg::RIDX_W'(r), '0, 1'b0, NO_OUTCOME);
            end
        for (int r = 0; r < NRES; r++)
            issue_command(dde_pkg::MODE_AVAIL, '0, dde_pkg::RIDX_W'(r), '0,
                          1'b0, NO_OUTCOME);

        no_idle = 1'b0;
        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].kind)
                ROW_ITEM:
                    issue_command(DIRECTED[i].op, DIRECTED[i].pidx, DIRECTED[i].ridx,
                                  DIRECTED[i].units, DIRECTED[i].typed, DIRECTED[i].outcome);
                ROW_PCOUNT:
                begin
                    settle_idle();
                    write_register(dde_pkg::REG_PROCESS_COUNT,
                                   dde_pkg::APB_DW'(DIRECTED[i].units));
                end
                default:
                begin
                    settle_idle();
                    write_register(dde_pkg::REG_RESOURCE_COUNT,
                                   dde_pkg::APB_DW'(DIRECTED[i].units));
                end
            endcase
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                settle_idle();
                if ($urandom_range(0, 3) != 0)
                    case ($urandom_range(0, 9))
                        0: write_register(dde_pkg::REG_PROCESS_COUNT, 0);
                        1: write_register(dde_pkg::REG_PROCESS_COUNT, $urandom_range(17, 31));
                        2, 3: write_register(dde_pkg::REG_PROCESS_COUNT, NPROC);
                        default: write_register(dde_pkg::REG_PROCESS_COUNT,
                                                $urandom_range(1, 6));
                    endcase
                if ($urandom_range(0, 3) != 0)
                    case ($urandom_range(0, 9))
                        0: write_register(dde_pkg::REG_RESOURCE_COUNT, 0);
                        1: write_register(dde_pkg::REG_RESOURCE_COUNT, $urandom_range(9, 15));
                        2: write_register(dde_pkg::REG_RESOURCE_COUNT, NRES);
                        default: write_register(dde_pkg::REG_RESOURCE_COUNT,
                                                $urandom_range(1, NRES));
                    endcase
            end
            np = active_count(int'(pcount_reg), NPROC);
            nr = active_count(int'(rcount_reg), NRES);

            if ($urandom_range(0, 1) == 0)
            begin
                // Ordered chain on one resource: the process of rank k needs k units,
                // and a finish mostly frees one more; a broken chain adds np to one request
                rr = $urandom_range(0, nr - 1);
                for (int k = 0; k < np; k++)
                    rank[k] = k;
                for (int k = np - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    tmp = rank[k];
                    rank[k] = rank[j];
                    rank[j] = tmp;
                end
                victim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, np - 1) : -1;
                issue_command(dde_pkg::MODE_AVAIL, dde_pkg::PIDX_W'($urandom),
                              dde_pkg::RIDX_W'(rr), '0, 1'b0, NO_OUTCOME);
                random_items++;
                for (int p = 0; p < np; p++)
                begin
                    units = dde_pkg::VALUE_W'(rank[p] + ((p == victim) ? np : 0));
                    issue_command(dde_pkg::MODE_REQUEST, dde_pkg::PIDX_W'(p),
                                  dde_pkg::RIDX_W'(rr), units, 1'b0, NO_OUTCOME);
                    units = ($urandom_range(0, 3) == 0) ? rand_units() : dde_pkg::VALUE_W'(1);
                    issue_command(dde_pkg::MODE_ALLOC, dde_pkg::PIDX_W'(p),
                                  dde_pkg::RIDX_W'(rr), units, 1'b0, NO_OUTCOME);
                    random_items += 2;
                end
            end
            else
            begin
                loads = $urandom_range(1, 6);
                for (int k = 0; k < loads; k++)
                begin
                    issue_command(dde_pkg::mode_t'($urandom_range(0, 2)),
                                  dde_pkg::PIDX_W'($urandom), dde_pkg::RIDX_W'($urandom),
                                  rand_units(), 1'b0, NO_OUTCOME);
                    random_items++;
                end
            end

            issue_command(dde_pkg::MODE_RUN, dde_pkg::PIDX_W'($urandom),
                          dde_pkg::RIDX_W'($urandom), dde_pkg::VALUE_W'($urandom),
                          1'b0, NO_OUTCOME);
            random_items++;
            // a second run sees the available vector the first one left behind
            if ($urandom_range(0, 3) == 0)
            begin
                issue_command(dde_pkg::MODE_RUN, dde_pkg::PIDX_W'($urandom),
                              dde_pkg::RIDX_W'($urandom), dde_pkg::VALUE_W'($urandom),
                              1'b0, NO_OUTCOME);
                random_items++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (result_errors == 0 && register_errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
